/* hw/rtl/vmpc_stream_cipher_mac_top_macros.svh */
`ifndef VMPC_STREAM_CIPHER_MAC_TOP_MACROS_SVH
`define VMPC_STREAM_CIPHER_MAC_TOP_MACROS_SVH

// concurrent check on a given clock and active-low reset
`define VMPC_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent check on clk_i and rst_ni
`define VMPC_ASSERT(lbl, prop, msg) `VMPC_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

/* hw/rtl/vmpc_pkg.sv */
`default_nettype none

package vmpc_pkg;

  localparam int unsigned DefMaxKeyBytes = 64;
  localparam int unsigned DefMaxIvBytes  = 64;
  localparam int unsigned KsaRounds      = 768;
  localparam int unsigned TailRounds     = 24;
  localparam int unsigned MacOutBytes    = 20;
  localparam int unsigned AccBytes       = 32;

  localparam logic [2:0] OpKey     = 3'd0;
  localparam logic [2:0] OpIv      = 3'd1;
  localparam logic [2:0] OpInit    = 3'd2;
  localparam logic [2:0] OpEncMac  = 3'd3;
  localparam logic [2:0] OpDecMac  = 3'd4;
  localparam logic [2:0] OpFinal   = 3'd5;
  localparam logic [2:0] OpEncOnly = 3'd6;
  localparam logic [2:0] OpSpare   = 3'd7;

  localparam logic [1:0] KindData = 2'd0;
  localparam logic [1:0] KindMac  = 2'd1;
  localparam logic [1:0] KindInit = 2'd2;

  localparam logic RegKeyLen = 1'b0;
  localparam logic RegIvLen  = 1'b1;

  typedef struct packed {
    logic       clr;
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } perm_req_t;

endpackage

`default_nettype wire

/* hw/rtl/vmpc_perm.sv */
`default_nettype none

module vmpc_perm (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  vmpc_pkg::perm_req_t req_i,
  output logic [7:0]          rd_o
);
  import vmpc_pkg::*;

  logic [7:0]   mem [256];
  logic [255:0] vld_q;
  logic [7:0]   rd_q;

  // entry without valid bit reads as identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.clr) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= vld_q[req_i.raddr] ? mem[req_i.raddr] : req_i.raddr;
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

/* hw/rtl/vmpc_stream_cipher_mac_top.sv */
// key or iv byte: stored on acceptance, no output; encrypt-only: keystream step, then output; with mac: also mac update
// init: three schedule passes (key, iv, key), 2304 rounds in all, each round stepping through states SK0 to SK4
// finalize: tail rounds, rekey from the mac accumulator and 20 mac bytes, held longer by output stalls
// one item at a time; each step waits on the registered read of the permutation table
// reset: identity permutation, zero s, i and mac state, both lengths 16; key and iv stores undefined
`default_nettype none

module vmpc_stream_cipher_mac_top #(
  parameter int unsigned MaxKeyBytes = vmpc_pkg::DefMaxKeyBytes,
  parameter int unsigned MaxIvBytes  = vmpc_pkg::DefMaxIvBytes
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [2:0] op_i,
  input  wire  [7:0] in_byte_i,
  input  wire  [5:0] byte_index_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] out_kind_o,
  output logic       last_o,
  input  wire        cfg_we_i,
  input  wire        cfg_idx_i,
  input  wire  [6:0] cfg_data_i
);
  import vmpc_pkg::*;

  `include "vmpc_stream_cipher_mac_top_macros.svh"

  localparam int unsigned KeyAw = (MaxKeyBytes > 1) ? $clog2(MaxKeyBytes) : 1;
  localparam int unsigned IvAw  = (MaxIvBytes > 1) ? $clog2(MaxIvBytes) : 1;

  localparam logic [4:0] SIdle = 5'd0;
  localparam logic [4:0] SK0   = 5'd1;
  localparam logic [4:0] SK1   = 5'd2;
  localparam logic [4:0] SK2   = 5'd3;
  localparam logic [4:0] SK3   = 5'd4;
  localparam logic [4:0] SK4   = 5'd5;
  localparam logic [4:0] SN0   = 5'd6;
  localparam logic [4:0] SN1   = 5'd7;
  localparam logic [4:0] SN2   = 5'd8;
  localparam logic [4:0] SN3   = 5'd9;
  localparam logic [4:0] SN4   = 5'd10;
  localparam logic [4:0] SN5   = 5'd11;
  localparam logic [4:0] SM0   = 5'd12;
  localparam logic [4:0] SM1   = 5'd13;
  localparam logic [4:0] SM2   = 5'd14;
  localparam logic [4:0] SM3   = 5'd15;
  localparam logic [4:0] SM4   = 5'd16;
  localparam logic [4:0] SAcc  = 5'd17;
  localparam logic [4:0] SW0   = 5'd18;
  localparam logic [4:0] SW1   = 5'd19;
  localparam logic [4:0] SEmit = 5'd20;

  localparam logic [1:0] PassKeyA = 2'd0;
  localparam logic [1:0] PassIv   = 2'd1;
  localparam logic [1:0] PassKeyB = 2'd2;
  localparam logic [1:0] PassAcc  = 2'd3;

  logic [4:0] state_q;
  logic [6:0] key_len_q, iv_len_q;
  logic [2:0] op_q;
  logic [7:0] b_q, i_q, s_q, pi_q, ps_q, ks_q, k_q;
  logic [7:0] r1_q, r2_q, r3_q, r4_q;
  logic [7:0] acc_q [AccBytes];
  logic [4:0] pos_q;
  logic [1:0] j_q, pass_q;
  logic [9:0] rnd_q;
  logic [4:0] cnt_q;
  logic       stage_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic [1:0] out_kind_q;
  logic       out_last_q;

  logic [7:0] key_mem [MaxKeyBytes];
  logic [7:0] iv_mem [MaxIvBytes];
  logic [7:0] key_rd_q, iv_rd_q;

  perm_req_t  preq;
  logic [7:0] rd;
  logic       in_fire, tail, with_mac, emit_go;
  logic [8:0] idx9, key_len9, iv_len9;
  logic [7:0] key_last, iv_last, k_last, kd, x, c;
  logic [4:0] acc_idx;
  logic [7:0] r_sel;

  vmpc_perm u_perm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (preq),
    .rd_o   (rd)
  );

  assign in_ready_o  = (state_q == SIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_kind_o  = out_kind_q;
  assign last_o      = out_last_q;

  assign idx9     = {3'b000, byte_index_i};
  assign key_len9 = {2'b00, key_len_q};
  assign iv_len9  = {2'b00, iv_len_q};

  always_comb begin
    if (key_len_q == 7'd0) begin
      key_last = 8'd0;
    end else if (key_len9 > 9'(MaxKeyBytes)) begin
      key_last = 8'(MaxKeyBytes - 1);
    end else begin
      key_last = 8'(key_len9 - 9'd1);
    end
    if (iv_len_q == 7'd0) begin
      iv_last = 8'd0;
    end else if (iv_len9 > 9'(MaxIvBytes)) begin
      iv_last = 8'(MaxIvBytes - 1);
    end else begin
      iv_last = 8'(iv_len9 - 9'd1);
    end
  end

  always_comb begin
    case (pass_q)
      PassIv: begin
        kd     = iv_rd_q;
        k_last = iv_last;
      end
      PassAcc: begin
        kd     = acc_q[k_q[4:0]];
        k_last = 8'(AccBytes - 1);
      end
      default: begin
        kd     = key_rd_q;
        k_last = key_last;
      end
    endcase
  end

  assign tail     = (op_q == OpFinal) && !stage_q;
  assign with_mac = (op_q == OpEncMac) || (op_q == OpDecMac) || tail;
  assign x        = tail ? {3'b000, cnt_q} : 8'd0;
  assign emit_go  = !out_valid_q || out_ready_i;
  assign acc_idx  = pos_q + {3'b000, j_q};

  always_comb begin
    case (op_q)
      OpEncMac: c = b_q ^ ks_q;
      OpDecMac: c = b_q;
      default:  c = 8'd0;
    endcase
    case (j_q)
      2'd0:    r_sel = r1_q;
      2'd1:    r_sel = r2_q;
      2'd2:    r_sel = r3_q;
      default: r_sel = r4_q;
    endcase
  end

  always_comb begin
    preq       = '0;
    preq.clr   = in_fire && (op_i == OpInit);
    preq.raddr = i_q;
    case (state_q)
      SK1:     preq.raddr = s_q + rd + kd;
      SN1:     preq.raddr = s_q + rd;
      SK2, SN2, SN3: preq.raddr = rd;
      SN4:     preq.raddr = rd + 8'd1;
      SM0:     preq.raddr = r4_q + r3_q + x;
      SM1:     preq.raddr = r3_q + r2_q + x;
      SM2:     preq.raddr = r2_q + r1_q + x;
      SM3:     preq.raddr = r1_q + s_q + c + x;
      SK3: begin
        preq.we    = 1'b1;
        preq.waddr = i_q;
        preq.wdata = rd;
      end
      SK4, SW1: begin
        preq.we    = 1'b1;
        preq.waddr = s_q;
        preq.wdata = pi_q;
      end
      SW0: begin
        preq.we    = 1'b1;
        preq.waddr = i_q;
        preq.wdata = ps_q;
      end
      default: preq.raddr = i_q;
    endcase
  end

  // key and iv stores
  always_ff @(posedge clk_i) begin
    if (in_fire && (op_i == OpKey) && (idx9 < 9'(MaxKeyBytes))) begin
      key_mem[idx9[KeyAw-1:0]] <= in_byte_i;
    end
    if (in_fire && (op_i == OpIv) && (idx9 < 9'(MaxIvBytes))) begin
      iv_mem[idx9[IvAw-1:0]] <= in_byte_i;
    end
    key_rd_q <= key_mem[k_q[KeyAw-1:0]];
    iv_rd_q  <= iv_mem[k_q[IvAw-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= 7'd16;
      iv_len_q  <= 7'd16;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegKeyLen) begin
        key_len_q <= cfg_data_i;
      end else begin
        iv_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      op_q        <= OpKey;
      b_q         <= '0;
      i_q         <= '0;
      s_q         <= '0;
      pi_q        <= '0;
      ps_q        <= '0;
      ks_q        <= '0;
      k_q         <= '0;
      r1_q        <= '0;
      r2_q        <= '0;
      r3_q        <= '0;
      r4_q        <= '0;
      acc_q       <= '{default: 8'd0};
      pos_q       <= '0;
      j_q         <= '0;
      pass_q      <= PassKeyA;
      rnd_q       <= '0;
      cnt_q       <= '0;
      stage_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_kind_q  <= KindData;
      out_last_q  <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (in_fire) begin
            op_q <= op_i;
            b_q  <= in_byte_i;
            case (op_i)
              OpInit: begin
                s_q    <= '0;
                i_q    <= '0;
                k_q    <= '0;
                rnd_q  <= '0;
                pass_q <= PassKeyA;
                r1_q   <= '0;
                r2_q   <= '0;
                r3_q   <= '0;
                r4_q   <= '0;
                pos_q  <= '0;
                acc_q  <= '{default: 8'd0};
                state_q <= SK0;
              end
              OpEncMac, OpDecMac, OpEncOnly: state_q <= SN0;
              OpFinal: begin
                cnt_q   <= 5'd1;
                stage_q <= 1'b0;
                state_q <= SN0;
              end
              default: state_q <= SIdle;
            endcase
          end
        end
        SK0: state_q <= SK1;
        SK1: begin
          pi_q    <= rd;
          state_q <= SK2;
        end
        SK2: begin
          s_q     <= rd;
          state_q <= SK3;
        end
        SK3: state_q <= SK4;
        SK4: begin
          i_q   <= i_q + 8'd1;
          k_q   <= (k_q == k_last) ? 8'd0 : k_q + 8'd1;
          rnd_q <= rnd_q + 10'd1;
          state_q <= SK0;
          if (rnd_q == 10'(KsaRounds - 1)) begin
            rnd_q <= '0;
            k_q   <= '0;
            i_q   <= '0;
            if (pass_q == PassKeyB) begin
              state_q <= SEmit;
            end else if (pass_q == PassAcc) begin
              r1_q    <= '0;
              r2_q    <= '0;
              r3_q    <= '0;
              r4_q    <= '0;
              pos_q   <= '0;
              acc_q   <= '{default: 8'd0};
              stage_q <= 1'b1;
              cnt_q   <= '0;
              state_q <= SN0;
            end else begin
              pass_q <= pass_q + 2'd1;
            end
          end
        end
        SN0: state_q <= SN1;
        SN1: begin
          pi_q    <= rd;
          state_q <= SN2;
        end
        SN2: begin
          s_q     <= rd;
          state_q <= SN3;
        end
        SN3: begin
          ps_q    <= rd;
          state_q <= SN4;
        end
        SN4: state_q <= SN5;
        SN5: begin
          ks_q    <= rd;
          state_q <= with_mac ? SM0 : SW0;
        end
        SM0: state_q <= SM1;
        SM1: begin
          r4_q    <= rd;
          state_q <= SM2;
        end
        SM2: begin
          r3_q    <= rd;
          state_q <= SM3;
        end
        SM3: begin
          r2_q    <= rd;
          state_q <= SM4;
        end
        SM4: begin
          r1_q    <= rd;
          j_q     <= '0;
          state_q <= SAcc;
        end
        SAcc: begin
          acc_q[acc_idx] <= acc_q[acc_idx] ^ r_sel;
          j_q <= j_q + 2'd1;
          if (j_q == 2'd3) begin
            pos_q   <= pos_q + 5'd4;
            state_q <= SW0;
          end
        end
        SW0: state_q <= SW1;
        SW1: begin
          i_q <= i_q + 8'd1;
          if (tail) begin
            if (cnt_q == 5'(TailRounds)) begin
              pass_q  <= PassAcc;
              i_q     <= '0;
              k_q     <= '0;
              rnd_q   <= '0;
              state_q <= SK0;
            end else begin
              cnt_q   <= cnt_q + 5'd1;
              state_q <= SN0;
            end
          end else begin
            state_q <= SEmit;
          end
        end
        SEmit: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            case (op_q)
              OpInit: begin
                out_byte_q <= 8'd0;
                out_kind_q <= KindInit;
                out_last_q <= 1'b1;
              end
              OpFinal: begin
                out_byte_q <= ks_q;
                out_kind_q <= KindMac;
                out_last_q <= (cnt_q == 5'(MacOutBytes - 1));
              end
              default: begin
                out_byte_q <= b_q ^ ks_q;
                out_kind_q <= KindData;
                out_last_q <= 1'b1;
              end
            endcase
            if ((op_q == OpFinal) && (cnt_q != 5'(MacOutBytes - 1))) begin
              cnt_q   <= cnt_q + 5'd1;
              state_q <= SN0;
            end else begin
              state_q <= SIdle;
            end
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `VMPC_ASSERT(a_clr_no_write, preq.clr |-> !preq.we, "permutation clear with write")
  `VMPC_ASSERT(a_rnd_range, rnd_q <= 10'(KsaRounds - 1), "schedule round count out of range")
  `VMPC_ASSERT(a_pos_aligned, (state_q == SIdle) |-> (pos_q[1:0] == 2'd0), "mac position misaligned")
  `VMPC_ASSERT(a_init_start, (in_fire && (op_i == OpInit)) |=> (state_q == SK0), "init did not start schedule")

endmodule

`default_nettype wire
